// File: design/lpps_pkg.sv
// lpps_pkg: shared types and codes for the led pulse pattern sequencer
// holds request codes, mode encoding and the request/response beat structs
// no dependencies
package lpps_pkg;

    localparam int TIME_BITS  = 16;
    localparam int COUNT_BITS = 8;

    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_PULSE  = 3'd1;
    localparam logic [2:0] REQ_ON     = 3'd2;
    localparam logic [2:0] REQ_OFF    = 3'd3;
    localparam logic [2:0] REQ_EXPIRE = 3'd4;

    typedef enum logic [2:0] {
        MODE_UNINIT = 3'd0,
        MODE_SOFF   = 3'd1,
        MODE_SON    = 3'd2,
        MODE_PON    = 3'd3,
        MODE_POFF   = 3'd4,
        MODE_GAP    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [TIME_BITS-1:0]  on_time;
        logic [TIME_BITS-1:0]  off_time;
        logic [TIME_BITS-1:0]  gap_time;
        logic [COUNT_BITS-1:0] burst_count;
    } req_t;

    typedef struct packed {
        logic                 led_level;
        logic                 timer_start;
        logic [TIME_BITS-1:0] timer_length;
        logic                 ignored;
        logic [2:0]           mode_now;
    } rsp_t;

endpackage

// File: design/led_pulse_pattern_sequencer.sv
// led_pulse_pattern_sequencer: request beat registered in lpps_in_stage, response beat registered in lpps_out_stage
// throughput one event per cycle while the response side holds ready high, set by the mode update in lpps_fsm
// both channels stall only when the response side holds ready low
// reset (rst_n low, asynchronous) empties both registers, mode uninitialised,
// led dark, stored times zero, burst one
module led_pulse_pattern_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lpps_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lpps_pkg::rsp_t rsp
);

    logic           item_valid;
    logic           item_take;
    logic           result_ready;
    lpps_pkg::req_t item;
    lpps_pkg::rsp_t result;

    assign item_take = item_valid && result_ready;

    lpps_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    lpps_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_take),
        .item   (item),
        .result (result)
    );

    lpps_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (item_valid),
        .result_ready (result_ready),
        .result       (result),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

endmodule

// File: design/lpps_in_stage.sv
// lpps_in_stage: input register holding one request beat
// depends on lpps_pkg
module lpps_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lpps_pkg::req_t req,
    output logic          item_valid,
    input  logic          item_take,
    output lpps_pkg::req_t item
);

    logic          valid_reg;
    logic          valid_next;
    lpps_pkg::req_t data_reg;

    // room when empty or when the held beat leaves this cycle
    assign req_ready  = !valid_reg || item_take;
    assign valid_next = (req_valid && req_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            data_reg <= req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// File: design/lpps_fsm.sv
// lpps_fsm: mode state machine, stored pattern and per-event result logic
// depends on lpps_pkg
module lpps_fsm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  lpps_pkg::req_t item,
    output lpps_pkg::rsp_t result
);

    lpps_pkg::mode_t mode_reg;
    lpps_pkg::mode_t mode_next;
    logic            led_reg;
    logic            led_next;
    logic [lpps_pkg::TIME_BITS-1:0]  on_reg;
    logic [lpps_pkg::TIME_BITS-1:0]  on_next;
    logic [lpps_pkg::TIME_BITS-1:0]  off_reg;
    logic [lpps_pkg::TIME_BITS-1:0]  off_next;
    logic [lpps_pkg::TIME_BITS-1:0]  gap_reg;
    logic [lpps_pkg::TIME_BITS-1:0]  gap_next;
    logic [lpps_pkg::COUNT_BITS-1:0] burst_reg;
    logic [lpps_pkg::COUNT_BITS-1:0] burst_next;
    logic [lpps_pkg::COUNT_BITS-1:0] left_reg;
    logic [lpps_pkg::COUNT_BITS-1:0] left_next;
    logic [lpps_pkg::COUNT_BITS-1:0] left_dec;
    logic                            single;

    assign left_dec = left_reg - lpps_pkg::COUNT_BITS'(1);
    assign single   = (item.burst_count <= lpps_pkg::COUNT_BITS'(1));

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        led_next   = led_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        gap_next   = gap_reg;
        burst_next = burst_reg;
        left_next  = left_reg;
        if (mode_reg == lpps_pkg::MODE_UNINIT)
        begin
            if (item.req_type == lpps_pkg::REQ_INIT)
            begin
                mode_next = lpps_pkg::MODE_SOFF;
                led_next  = 1'b0;
            end
        end
        else
        begin
            case (item.req_type)
                lpps_pkg::REQ_PULSE:
                begin
                    on_next    = item.on_time;
                    off_next   = item.off_time;
                    gap_next   = single ? '0 : item.gap_time;
                    burst_next = single ? lpps_pkg::COUNT_BITS'(1) : item.burst_count;
                    left_next  = single ? lpps_pkg::COUNT_BITS'(1) : item.burst_count;
                    mode_next  = lpps_pkg::MODE_PON;
                    led_next   = 1'b1;
                end
                lpps_pkg::REQ_ON:
                begin
                    mode_next = lpps_pkg::MODE_SON;
                    led_next  = 1'b1;
                end
                lpps_pkg::REQ_OFF:
                begin
                    mode_next = lpps_pkg::MODE_SOFF;
                    led_next  = 1'b0;
                end
                lpps_pkg::REQ_EXPIRE:
                begin
                    case (mode_reg)
                        lpps_pkg::MODE_PON:
                        begin
                            mode_next = lpps_pkg::MODE_POFF;
                            led_next  = 1'b0;
                        end
                        lpps_pkg::MODE_POFF:
                        begin
                            if (left_dec != '0)
                            begin
                                left_next = left_dec;
                                mode_next = lpps_pkg::MODE_PON;
                                led_next  = 1'b1;
                            end
                            else if (gap_reg == '0)
                            begin
                                left_next = burst_reg;
                                mode_next = lpps_pkg::MODE_PON;
                                led_next  = 1'b1;
                            end
                            else
                            begin
                                left_next = left_dec;
                                mode_next = lpps_pkg::MODE_GAP;
                            end
                        end
                        lpps_pkg::MODE_GAP:
                        begin
                            left_next = burst_reg;
                            mode_next = lpps_pkg::MODE_PON;
                            led_next  = 1'b1;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // result for this event
    always_comb
    begin
        result.led_level    = led_next;
        result.mode_now     = mode_next;
        result.timer_start  = 1'b0;
        result.timer_length = '0;
        result.ignored      = 1'b0;
        if (mode_reg == lpps_pkg::MODE_UNINIT)
        begin
            result.ignored = (item.req_type != lpps_pkg::REQ_INIT);
        end
        else
        begin
            case (item.req_type)
                lpps_pkg::REQ_PULSE:
                begin
                    result.timer_start  = 1'b1;
                    result.timer_length = item.on_time;
                end
                lpps_pkg::REQ_ON:
                begin
                    result.ignored = (mode_reg == lpps_pkg::MODE_SON);
                end
                lpps_pkg::REQ_OFF:
                begin
                    result.ignored = (mode_reg == lpps_pkg::MODE_SOFF);
                end
                lpps_pkg::REQ_EXPIRE:
                begin
                    case (mode_reg)
                        lpps_pkg::MODE_PON:
                        begin
                            result.timer_start  = 1'b1;
                            result.timer_length = off_reg;
                        end
                        lpps_pkg::MODE_POFF:
                        begin
                            result.timer_start = 1'b1;
                            if (left_dec == '0 && gap_reg != '0)
                            begin
                                result.timer_length = gap_reg;
                            end
                            else
                            begin
                                result.timer_length = on_reg;
                            end
                        end
                        lpps_pkg::MODE_GAP:
                        begin
                            result.timer_start  = 1'b1;
                            result.timer_length = on_reg;
                        end
                        default:
                        begin
                            result.ignored = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    result.ignored = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lpps_pkg::MODE_UNINIT;
            led_reg   <= 1'b0;
            on_reg    <= '0;
            off_reg   <= '0;
            gap_reg   <= '0;
            burst_reg <= lpps_pkg::COUNT_BITS'(1);
            left_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            led_reg   <= led_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            gap_reg   <= gap_next;
            burst_reg <= burst_next;
            left_reg  <= left_next;
        end
    end

endmodule

// File: design/lpps_out_stage.sv
// lpps_out_stage: result register in front of the response channel
// depends on lpps_pkg
module lpps_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           result_valid,
    output logic           result_ready,
    input  lpps_pkg::rsp_t result,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lpps_pkg::rsp_t rsp
);

    logic           valid_reg;
    logic           valid_next;
    lpps_pkg::rsp_t data_reg;

    assign result_ready = !valid_reg || rsp_ready;
    assign valid_next   = result_ready ? result_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            data_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

// File: design/lpps_checker.sv
// lpps_checker: port-level checks on the sequencer responses, bound to the top level
// depends on lpps_pkg and led_pulse_pattern_sequencer
module lpps_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input lpps_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input lpps_pkg::rsp_t rsp
);

    logic seen_init_reg;
    logic seen_init_next;

    // once a response leaves the uninitialised mode it never returns there
    assign seen_init_next = seen_init_reg
        || (rsp_valid && rsp_ready && rsp.mode_now != lpps_pkg::MODE_UNINIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_init_reg <= 1'b0;
        end
        else
        begin
            seen_init_reg <= seen_init_next;
        end
    end

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request beat dropped or changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat dropped or changed while stalled");

    a_no_timer_when_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.ignored || !rsp.timer_start) |-> !rsp.timer_start
            && rsp.timer_length == '0)
        else $error("timer request on an ignored or timerless event");

    a_led_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.led_level == (rsp.mode_now == lpps_pkg::MODE_SON
            || rsp.mode_now == lpps_pkg::MODE_PON))
        else $error("led level disagrees with mode");

    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_init_reg |-> rsp.mode_now != lpps_pkg::MODE_UNINIT)
        else $error("mode fell back to uninitialised");

endmodule

bind led_pulse_pattern_sequencer lpps_checker u_lpps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
